FILE: src/lbtk_pkg.sv
// Shared types and constants for the largest-blob top-k filter.
package lbtk_pkg;

   localparam int LIST_CAPACITY = 64;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_W         = 24;
   localparam int CSR_INDEX_W   = 1;
   localparam int COUNT_W       = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SIZE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_KEPT = 1'd1;

   localparam logic [1:0] VERDICT_KEPT    = 2'd0;
   localparam logic [1:0] VERDICT_REMOVED = 2'd1;
   localparam logic [1:0] VERDICT_SPARED  = 2'd2;

   localparam logic [1:0] KIND_REMOVE  = 2'd0;
   localparam logic [1:0] KIND_DROP    = 2'd1;
   localparam logic [1:0] KIND_COMPETE = 2'd2;

   typedef struct packed {
      logic [15:0] label;
      logic        is_root;
      logic [23:0] size;
      logic        protect;
      logic        table_end;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_label;
      logic [1:0]         verdict;
      logic [COUNT_W-1:0] kept_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] label;
      logic [23:0] size;
      logic        protect;
      logic        table_end;
   } item_type;

endpackage

FILE: src/lbtk_fifo.sv
// Small first-word-fall-through queue.
module lbtk_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = lbtk_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/lbtk_front.sv
// Front end: configuration registers and classification of incoming records.
module lbtk_front #(
   parameter int LIST_CAPACITY = lbtk_pkg::LIST_CAPACITY,
   localparam int CNT_W = $clog2(LIST_CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [lbtk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbtk_pkg::CSR_W-1:0]     csr_data,
   input  lbtk_pkg::req_type              req,
   output lbtk_pkg::item_type             item,
   output logic [CNT_W-1:0]               limit
);
   logic [23:0] min_size_ff;
   logic [7:0]  max_kept_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= '0;
         max_kept_ff <= 8'hFF;
      end else if (csr_write) begin
         case (csr_index)
            lbtk_pkg::CSR_MIN_SIZE: min_size_ff <= csr_data;
            lbtk_pkg::CSR_MAX_KEPT: max_kept_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Negative limit means the whole list; large values saturate at capacity.
   always_comb begin
      int mk;
      mk = int'(max_kept_ff[6:0]);
      if (max_kept_ff[7] || mk > LIST_CAPACITY) begin
         limit = CNT_W'(LIST_CAPACITY);
      end else begin
         limit = CNT_W'(mk);
      end
   end

   always_comb begin
      item.label     = req.label;
      item.size      = req.size;
      item.protect   = req.protect;
      item.table_end = req.table_end;
      if (!req.is_root) begin
         item.kind = lbtk_pkg::KIND_REMOVE;
      end else if (req.size < min_size_ff || limit == '0) begin
         item.kind = lbtk_pkg::KIND_DROP;
      end else begin
         item.kind = lbtk_pkg::KIND_COMPETE;
      end
   end

endmodule

FILE: src/lbtk_back.sv
// Back end: sorted register chain of kept blobs and verdict sequencer.
module lbtk_back #(
   parameter int LIST_CAPACITY = lbtk_pkg::LIST_CAPACITY,
   localparam int CNT_W = $clog2(LIST_CAPACITY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   limit,
   input  lbtk_pkg::item_type item,
   input  logic               item_empty,
   output logic               item_pop,
   output lbtk_pkg::rsp_type  rsp,
   output logic               rsp_push,
   input  logic               rsp_full
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_APPLY = 2'd1;
   localparam logic [1:0] ST_EVICT = 2'd2;

   logic [1:0]         state_ff, state_in;
   lbtk_pkg::item_type item_ff;
   logic [CNT_W-1:0]   kept_total_ff, kept_total_in;

   logic [15:0] label_ff [LIST_CAPACITY];
   logic [23:0] size_ff  [LIST_CAPACITY];
   logic        prot_ff  [LIST_CAPACITY];
   logic [15:0] label_in [LIST_CAPACITY];
   logic [23:0] size_in  [LIST_CAPACITY];
   logic        prot_in  [LIST_CAPACITY];

   logic [15:0] tail_label_ff, tail_label_in;
   logic [23:0] tail_size_ff, tail_size_in;
   logic        tail_prot_ff, tail_prot_in;

   logic                     compete, has_room, evict, do_insert, apply_fire;
   logic [CNT_W-1:0]         eff_total, new_total, tail_index;
   logic [LIST_CAPACITY-1:0] cmp;
   logic [1:0]               verdict_first;

   assign item_pop   = (state_ff == ST_IDLE) && !item_empty;
   assign tail_index = kept_total_ff - 1'b1;

   // Latch the smallest kept entry while the list is at rest.
   always_comb begin
      tail_label_in = '0;
      tail_size_in  = '0;
      tail_prot_in  = 1'b0;
      for (int i = 0; i < LIST_CAPACITY; i++) begin
         if (CNT_W'(i) == tail_index) begin
            tail_label_in = tail_label_in | label_ff[i];
            tail_size_in  = tail_size_in | size_ff[i];
            tail_prot_in  = tail_prot_in | prot_ff[i];
         end
      end
   end

   assign compete   = (item_ff.kind == lbtk_pkg::KIND_COMPETE);
   assign has_room  = (kept_total_ff < limit);
   assign evict     = compete && !has_room && !(tail_size_ff > item_ff.size);
   assign do_insert = compete && (has_room || evict);
   assign eff_total = kept_total_ff - CNT_W'(evict);
   assign new_total = eff_total + CNT_W'(do_insert);
   assign apply_fire = (state_ff == ST_APPLY) && !rsp_full;

   // A newcomer goes ahead of every kept blob that is not strictly larger.
   always_comb begin
      for (int i = 0; i < LIST_CAPACITY; i++) begin
         cmp[i] = (CNT_W'(i) >= eff_total) || (size_ff[i] <= item_ff.size);
      end
   end

   always_comb begin
      for (int i = 0; i < LIST_CAPACITY; i++) begin
         label_in[i] = label_ff[i];
         size_in[i]  = size_ff[i];
         prot_in[i]  = prot_ff[i];
         if (cmp[i]) begin
            if (i == 0 || !cmp[(i == 0) ? 0 : i - 1]) begin
               label_in[i] = item_ff.label;
               size_in[i]  = item_ff.size;
               prot_in[i]  = item_ff.protect;
            end else begin
               label_in[i] = label_ff[(i == 0) ? 0 : i - 1];
               size_in[i]  = size_ff[(i == 0) ? 0 : i - 1];
               prot_in[i]  = prot_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   always_comb begin
      case (item_ff.kind)
         lbtk_pkg::KIND_REMOVE: verdict_first = lbtk_pkg::VERDICT_REMOVED;
         lbtk_pkg::KIND_COMPETE: begin
            if (do_insert) begin
               verdict_first = lbtk_pkg::VERDICT_KEPT;
            end else begin
               verdict_first = item_ff.protect ? lbtk_pkg::VERDICT_SPARED
                                               : lbtk_pkg::VERDICT_REMOVED;
            end
         end
         default: verdict_first = item_ff.protect ? lbtk_pkg::VERDICT_SPARED
                                                  : lbtk_pkg::VERDICT_REMOVED;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kept_total_in = kept_total_ff;
      rsp_push      = 1'b0;
      rsp           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!item_empty) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            rsp.out_label  = item_ff.label;
            rsp.verdict    = verdict_first;
            rsp.kept_count = lbtk_pkg::COUNT_W'(new_total);
            rsp.last       = !evict;
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               kept_total_in = (item_ff.table_end && !evict) ? '0 : new_total;
               state_in      = evict ? ST_EVICT : ST_IDLE;
            end
         end
         ST_EVICT: begin
            rsp.out_label  = tail_label_ff;
            rsp.verdict    = tail_prot_ff ? lbtk_pkg::VERDICT_SPARED
                                          : lbtk_pkg::VERDICT_REMOVED;
            rsp.kept_count = lbtk_pkg::COUNT_W'(kept_total_ff);
            rsp.last       = 1'b1;
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               kept_total_in = item_ff.table_end ? '0 : kept_total_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kept_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         kept_total_ff <= kept_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         item_ff       <= item;
         tail_label_ff <= tail_label_in;
         tail_size_ff  <= tail_size_in;
         tail_prot_ff  <= tail_prot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_fire && do_insert) begin
         for (int i = 0; i < LIST_CAPACITY; i++) begin
            label_ff[i] <= label_in[i];
            size_ff[i]  <= size_in[i];
            prot_ff[i]  <= prot_in[i];
         end
      end
   end

   a_evict_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && evict) |-> (kept_total_ff != '0))
      else $error("eviction from an empty list");

   a_insert_fits: assert property (@(posedge clock) disable iff (reset)
      (apply_fire && do_insert) |-> (eff_total < CNT_W'(LIST_CAPACITY)))
      else $error("insert into a full list");

   a_evict_follows: assert property (@(posedge clock) disable iff (reset)
      (apply_fire && evict) |=> (state_ff == ST_EVICT && !item_pop))
      else $error("eviction transfer skipped");

   a_table_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp.last && item_ff.table_end) |=> (kept_total_ff == '0))
      else $error("list not cleared at table end");

endmodule

FILE: src/largest_blob_top_k_filter_core.sv
// Top level of the largest-blob top-k filter: front, queues and back.
//
//   channel | direction | handshake                | payload
//   req     | in        | req_push / req_full      | req_data  (lbtk_pkg::req_type)
//   rsp     | out       | rsp_pop / rsp_empty      | rsp_data  (lbtk_pkg::rsp_type)
//   csr     | in        | csr_write                | csr_index, csr_data
//
// In the back sequencer a record passes through IDLE (take it and latch the list
// tail) and APPLY (compare against every kept entry and update the chain); an eviction
// adds an EVICT state for its second result transfer.
// Reset is synchronous: it clears the queues and the kept count and resets the config;
// list entries stay undefined until written.
// Two-entry queues on both sides let records and results stall independently.
module largest_blob_top_k_filter_core #(
   parameter int LIST_CAPACITY = lbtk_pkg::LIST_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  lbtk_pkg::req_type                req_data,
   output logic                             req_full,
   input  logic                             rsp_pop,
   output lbtk_pkg::rsp_type                rsp_data,
   output logic                             rsp_empty,
   input  logic                             csr_write,
   input  logic [lbtk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbtk_pkg::CSR_W-1:0]       csr_data
);
   localparam int CNT_W = $clog2(LIST_CAPACITY + 1);

   lbtk_pkg::item_type front_item, back_item;
   lbtk_pkg::rsp_type  back_rsp;
   logic [CNT_W-1:0]   limit;
   logic               item_empty, item_pop, rsp_push, rsp_full;

   lbtk_front #(.LIST_CAPACITY(LIST_CAPACITY)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_data),
      .item      (front_item),
      .limit     (limit)
   );

   lbtk_fifo #(
      .WIDTH ($bits(lbtk_pkg::item_type)),
      .DEPTH (lbtk_pkg::QUEUE_DEPTH)
   ) u_item_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   lbtk_back #(.LIST_CAPACITY(LIST_CAPACITY)) u_back (
      .clock      (clock),
      .reset      (reset),
      .limit      (limit),
      .item       (back_item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .rsp        (back_rsp),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_full)
   );

   lbtk_fifo #(
      .WIDTH ($bits(lbtk_pkg::rsp_type)),
      .DEPTH (lbtk_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

FILE: dv/lbtk_verdict_checker.sv
// Verdict checker for the top-k blob filter: tracks the kept list and compares every result.
module lbtk_verdict_checker
   import lbtk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  req_type                req_data,
   input  logic                   rsp_pop,
   input  logic                   rsp_empty,
   input  rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_data,
   output int                     fail_count,
   output int                     outstanding,
   output int                     verdicts_seen,
   output int                     evictions
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0]       list_label [LIST_CAPACITY];
   logic [23:0]       list_size  [LIST_CAPACITY];
   logic              list_prot  [LIST_CAPACITY];
   int                list_len;
   logic [23:0]       cfg_min_size;
   logic signed [7:0] cfg_max_kept;
   rsp_type           awaited_verdicts [$];

   task automatic note_verdict(input logic [15:0] lab, input logic [1:0] v, input logic fin);
      rsp_type item;
      item.out_label  = lab;
      item.verdict    = v;
      item.kept_count = list_len[COUNT_W-1:0];
      item.last       = fin;
      awaited_verdicts.push_back(item);
   endtask

   // Insert ahead of any kept blob of equal size, keeping largest first.
   task automatic place_blob(input logic [15:0] lab, input logic [23:0] sz, input logic prot);
      int pos;
      pos = 0;
      if (list_len >= LIST_CAPACITY) return;
      while (pos < list_len && list_size[pos] > sz) pos++;
      for (int j = list_len; j > pos; j--) begin
         list_label[j] = list_label[j-1];
         list_size[j]  = list_size[j-1];
         list_prot[j]  = list_prot[j-1];
      end
      list_label[pos] = lab;
      list_size[pos]  = sz;
      list_prot[pos]  = prot;
      list_len++;
   endtask

   task automatic judge_record(input req_type rec);
      int         limit;
      int         tail;
      logic [1:0] drop_verdict;
      logic [15:0] ev_label;
      logic [1:0] ev_verdict;
      drop_verdict = rec.protect ? VERDICT_SPARED : VERDICT_REMOVED;
      if (cfg_max_kept < 0 || cfg_max_kept > LIST_CAPACITY) limit = LIST_CAPACITY;
      else limit = int'(cfg_max_kept);

      if (!rec.is_root) begin
         note_verdict(rec.label, VERDICT_REMOVED, 1'b1);
      end else if (rec.size < cfg_min_size || limit == 0) begin
         note_verdict(rec.label, drop_verdict, 1'b1);
      end else if (list_len < limit) begin
         place_blob(rec.label, rec.size, rec.protect);
         note_verdict(rec.label, VERDICT_KEPT, 1'b1);
      end else begin
         // A list over a lowered limit still counts as full: evict one at a time.
         tail = list_len - 1;
         if (list_size[tail] > rec.size) begin
            note_verdict(rec.label, drop_verdict, 1'b1);
         end else begin
            ev_label   = list_label[tail];
            ev_verdict = list_prot[tail] ? VERDICT_SPARED : VERDICT_REMOVED;
            list_len--;
            place_blob(rec.label, rec.size, rec.protect);
            note_verdict(rec.label, VERDICT_KEPT, 1'b0);
            note_verdict(ev_label, ev_verdict, 1'b1);
            evictions++;
         end
      end
      if (rec.table_end) list_len = 0;
   endtask

   task automatic check_verdict(input rsp_type got);
      rsp_type want;
      bit      bad;
      bad = 1'b0;
      verdicts_seen++;
      if (awaited_verdicts.size() == 0) begin
         $error("result with nothing expected: out_label %0d verdict %0d",
                got.out_label, got.verdict);
         fail_count++;
         return;
      end
      want = awaited_verdicts.pop_front();
      if (got.out_label !== want.out_label) begin
         $error("out_label: expected %0d, got %0d", want.out_label, got.out_label);
         bad = 1'b1;
      end
      if (got.verdict !== want.verdict) begin
         $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
         bad = 1'b1;
      end
      if (got.kept_count !== want.kept_count) begin
         $error("kept_count: expected %0d, got %0d", want.kept_count, got.kept_count);
         bad = 1'b1;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         bad = 1'b1;
      end
      if (bad) fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len      = 0;
         cfg_min_size  = '0;
         cfg_max_kept  = -8'sd1;
         fail_count    = 0;
         verdicts_seen = 0;
         evictions     = 0;
         awaited_verdicts.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_MIN_SIZE) cfg_min_size = csr_data[23:0];
            else if (csr_index == CSR_MAX_KEPT) cfg_max_kept = csr_data[7:0];
         end
         if (rsp_pop && !rsp_empty) check_verdict(rsp_data);
         if (req_push && !req_full) judge_record(req_data);
      end
      outstanding = awaited_verdicts.size();
   end

endmodule

FILE: dv/tb_largest_blob_top_k_filter_core.sv
// Testbench top for the top-k blob filter: clock, reset, stimulus and verdict.
module tb_largest_blob_top_k_filter_core;
   timeunit 1ns;
   timeprecision 1ps;
   import lbtk_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   req_type                req_data;
   logic                   req_full;
   logic                   rsp_pop;
   rsp_type                rsp_data;
   logic                   rsp_empty;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_data;

   int fail_count;
   int outstanding;
   int verdicts_seen;
   int evictions;

   bit send_idle;
   bit take_idle;
   int hold_request;
   int records_sent;
   int settings_used;

   largest_blob_top_k_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lbtk_verdict_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .verdicts_seen (verdicts_seen),
      .evictions     (evictions)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off when requested.
   initial begin : take_results
      int stall;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_pop = 1'b0;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
         end
         stall = take_idle ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   function automatic req_type make_record(input logic [15:0] lab, input logic root,
                                           input logic [23:0] sz, input logic prot,
                                           input logic fin);
      req_type rec;
      rec.label     = lab;
      rec.is_root   = root;
      rec.size      = sz;
      rec.protect   = prot;
      rec.table_end = fin;
      return rec;
   endfunction

   // Hold the record until the transfer happens.
   task automatic offer_record(input req_type rec);
      int gap;
      gap = send_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_data = rec;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      records_sent++;
   endtask

   task automatic settle_list();
      req_push = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_write = 1'b1;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic apply_setting(input logic [23:0] min_sz, input logic signed [7:0] max_k);
      settle_list();
      write_csr(CSR_MIN_SIZE, min_sz);
      write_csr(CSR_MAX_KEPT, {16'd0, max_k});
      settings_used++;
   endtask

   initial begin : make_stimulus
      int                p;
      int                n;
      int                table_len;
      int                table_pos;
      int                sz;
      bit                long_tables;
      logic [15:0]       label_base;
      logic [23:0]       min_sz;
      logic signed [7:0] max_k;
      req_type           rec;

      reset        = 1'b1;
      req_push     = 1'b0;
      req_data     = '0;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      send_idle    = 1'b1;
      take_idle    = 1'b1;
      hold_request = 0;
      records_sent = 0;
      settings_used = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Floor of 100, room for two: below floor, non-root, reject, evictions, ties.
      apply_setting(24'd100, 8'sd2);
      offer_record(make_record(16'd0,     1'b1, 24'd500,      1'b0, 1'b0));
      offer_record(make_record(16'hFFFF,  1'b0, 24'hFFFFFF,   1'b1, 1'b0));
      offer_record(make_record(16'd2,     1'b1, 24'd99,       1'b1, 1'b0));
      offer_record(make_record(16'd3,     1'b1, 24'd0,        1'b0, 1'b0));
      offer_record(make_record(16'd4,     1'b1, 24'd100,      1'b1, 1'b0));
      offer_record(make_record(16'd5,     1'b1, 24'd300,      1'b0, 1'b0));
      offer_record(make_record(16'd6,     1'b1, 24'd200,      1'b1, 1'b0));
      offer_record(make_record(16'd7,     1'b1, 24'd300,      1'b0, 1'b0));
      offer_record(make_record(16'd8,     1'b1, 24'hFFFFFF,   1'b0, 1'b1));

      // Nothing may be kept.
      apply_setting(24'd0, 8'sd0);
      offer_record(make_record(16'd9,  1'b1, 24'd1000,    1'b1, 1'b0));
      offer_record(make_record(16'd10, 1'b1, 24'hFFFFFF,  1'b0, 1'b1));

      // Most negative limit means unlimited.
      apply_setting(24'd0, -8'sd128);
      offer_record(make_record(16'd11, 1'b1, 24'd7, 1'b1, 1'b0));
      offer_record(make_record(16'd12, 1'b1, 24'd7, 1'b0, 1'b1));

      // Lower the limit below the list length mid-table.
      apply_setting(24'd0, 8'sd5);
      offer_record(make_record(16'd20, 1'b1, 24'd40, 1'b0, 1'b0));
      offer_record(make_record(16'd21, 1'b1, 24'd30, 1'b1, 1'b0));
      offer_record(make_record(16'd22, 1'b1, 24'd20, 1'b0, 1'b0));
      offer_record(make_record(16'd23, 1'b1, 24'd10, 1'b0, 1'b0));
      apply_setting(24'd0, 8'sd2);
      offer_record(make_record(16'd24, 1'b1, 24'd25, 1'b0, 1'b0));
      offer_record(make_record(16'd25, 1'b1, 24'd5,  1'b1, 1'b0));
      offer_record(make_record(16'd26, 1'b1, 24'd20, 1'b0, 1'b1));

      for (p = 0; p < 12; p++) begin
         case (p)
            0: begin min_sz = 24'd0;      max_k = -8'sd1;   end
            1: begin min_sz = 24'hFFFFFF; max_k = 8'sd64;   end
            2: begin min_sz = 24'd0;      max_k = 8'sd1;    end
            3: begin min_sz = 24'($urandom_range(0, 5000)); max_k = 8'sd127; end
            4: begin min_sz = 24'($urandom_range(0, 16777215)); max_k = -8'sd128; end
            default: begin
               case ($urandom_range(0, 3))
                  0: min_sz = 24'd0;
                  1: min_sz = 24'($urandom_range(1, 1000));
                  2: min_sz = 24'($urandom_range(0, 16777215));
                  default: min_sz = 24'hFFFFFF;
               endcase
               case ($urandom_range(0, 5))
                  0: max_k = -8'sd1;
                  1: max_k = 8'($urandom_range(1, 8));
                  2: max_k = 8'sd64;
                  3: max_k = 8'($urandom_range(65, 127));
                  4: max_k = 8'(-int'($urandom_range(1, 128)));
                  default: max_k = 8'sd0;
               endcase
            end
         endcase
         apply_setting(min_sz, max_k);
         send_idle   = (p % 3 != 1);
         take_idle   = (p % 4 != 1);
         long_tables = (p == 0) || ((max_k < 0 || max_k >= 32) && $urandom_range(0, 1));
         if (p == 5 || p == 9) hold_request = (p == 5) ? 300 : 150;

         table_pos = 0;
         table_len = 0;
         label_base = '0;
         for (n = 0; n < 140; n++) begin
            if (table_pos == table_len) begin
               table_len  = $urandom_range(1, long_tables ? 100 : 20);
               table_pos  = 0;
               label_base = 16'($urandom_range(0, 65535));
            end
            if ($urandom_range(0, 9) == 0) begin
               // noise: anything goes
               rec = make_record(label_base + table_pos[15:0], 1'($urandom_range(0, 1)),
                                 24'($urandom_range(0, 16777215)), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 7) == 0);
            end else begin
               case ($urandom_range(0, 3))
                  0: sz = (min_sz == 0) ? 0 : $urandom_range(0, min_sz - 1);
                  1, 2: sz = min_sz + $urandom_range(0, 15);
                  default: sz = min_sz + $urandom_range(0, 16777215 - min_sz);
               endcase
               if (sz > 16777215) sz = 16777215;
               rec = make_record(label_base + table_pos[15:0], $urandom_range(0, 15) != 0,
                                 sz[23:0], 1'($urandom_range(0, 1)),
                                 table_pos == table_len - 1);
            end
            offer_record(rec);
            table_pos++;
            // pause the sender until the list has answered everything
            if (n == 70 && p % 2 == 0) settle_list();
         end
      end

      settle_list();
      repeat (20) @(negedge clock);
      $display("Sent %0d blob records across %0d filter settings.",
               records_sent, settings_used);
      $display("Checked %0d verdicts, %0d predicted evictions.", verdicts_seen, evictions);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
src/lbtk_pkg.sv
src/lbtk_fifo.sv
src/lbtk_front.sv
src/lbtk_back.sv
src/largest_blob_top_k_filter_core.sv
dv/lbtk_verdict_checker.sv
dv/tb_largest_blob_top_k_filter_core.sv
